[sv/drd_pkg.sv]
// Shared types, constants and arithmetic helpers for the detection row decoder.
// No dependencies; used by every module of the block.
package drd_pkg;

  localparam int MAX_CLASSES_DEF = 80;
  localparam int Q_DEPTH_DEF     = 4;
  localparam int CLS_W           = 7;
  localparam int VAL_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int MASK_W          = 80;

  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH  = 3'd6;

  typedef struct packed {
    logic        layout_with_objectness;
    logic [15:0] score_threshold;
    logic [15:0] objectness_threshold;
    logic [15:0] x_scale;
    logic [15:0] y_scale;
    logic [63:0] class_mask_low;
    logic [15:0] class_mask_high;
  } cfg_t;

  // Detection record handed from front to back through the queue.
  typedef struct packed {
    logic [CLS_W-1:0] class_id;
    logic [VAL_W-1:0] score;
    logic [VAL_W-1:0] cx;
    logic [VAL_W-1:0] cy;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] h;
  } det_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Product in units of 2^-19: truncate toward zero, saturate to 13-bit signed.
  function automatic logic [12:0] sat_edge(input logic signed [34:0] p);
    logic        neg;
    logic [34:0] mag;
    logic [15:0] m;
    logic [12:0] r;
    neg = p[34];
    mag = neg ? 35'(-p) : 35'(p);
    m   = mag[34:19];
    if (neg) begin
      r = (m >= 16'd4096) ? 13'h1000 : 13'(-m[12:0]);
    end else begin
      r = (m > 16'd4095) ? 13'h0FFF : m[12:0];
    end
    return r;
  endfunction

  // Product in units of 2^-18: truncate, saturate to 4095.
  function automatic logic [11:0] sat_extent(input logic [31:0] p);
    logic [13:0] q;
    q = p[31:18];
    return (q > 14'd4095) ? 12'hFFF : q[11:0];
  endfunction

endpackage

[sv/drd_front.sv]
// Front end: accepts elements, tracks row position, box values and the class argmax,
// and pushes a detection record at a qualifying row end. Depends on drd_pkg.
module drd_front #(
  parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  drd_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [drd_pkg::VAL_W-1:0]  in_element_value,
  input  logic                       in_last_of_row,
  input  drd_pkg::q_status_t         q_stat,
  output logic                       q_push,
  output drd_pkg::det_t              q_wdata
);

  localparam logic [6:0] MaxCls = 7'(MAX_CLASSES);

  logic [6:0]                  pos_r;
  logic [drd_pkg::VAL_W-1:0]   box_r [4];
  logic [drd_pkg::VAL_W-1:0]   obj_r;
  logic [drd_pkg::VAL_W-1:0]   best_score_r, best_score_nxt;
  logic [drd_pkg::CLS_W-1:0]   best_class_r, best_class_nxt;

  logic [6:0]                  first;
  logic [6:0]                  idx;
  logic                        is_cls;
  logic                        upd;
  logic                        accept;
  logic                        emit;
  logic                        cls_en;
  logic [drd_pkg::MASK_W-1:0]  mask;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign first    = 7'd4 + {6'd0, cfg.layout_with_objectness};
  assign is_cls   = pos_r >= first;
  assign idx      = pos_r - first;
  assign upd      = is_cls && (idx < MaxCls) &&
                    ((idx == 7'd0) || (in_element_value > best_score_r));
  assign best_score_nxt = upd ? in_element_value : best_score_r;
  assign best_class_nxt = upd ? idx : best_class_r;
  assign mask     = {cfg.class_mask_high, cfg.class_mask_low};
  assign cls_en   = (best_class_nxt < 7'd80) ? mask[best_class_nxt] : 1'b0;
  assign emit     = is_cls && in_last_of_row &&
                    (best_score_nxt > cfg.score_threshold) &&
                    (!cfg.layout_with_objectness || (obj_r >= cfg.objectness_threshold)) &&
                    cls_en;
  assign q_push   = accept && emit;

  always_comb begin
    q_wdata.class_id = best_class_nxt;
    q_wdata.score    = best_score_nxt;
    q_wdata.cx       = box_r[0];
    q_wdata.cy       = box_r[1];
    q_wdata.w        = box_r[2];
    q_wdata.h        = box_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      box_r[0]     <= '0;
      box_r[1]     <= '0;
      box_r[2]     <= '0;
      box_r[3]     <= '0;
      obj_r        <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
    end else if (accept) begin
      if (pos_r < 7'd4) begin
        box_r[pos_r[1:0]] <= in_element_value;
      end else if (!is_cls) begin
        obj_r <= in_element_value;
      end
      if (in_last_of_row) begin
        pos_r        <= '0;
        best_score_r <= '0;
        best_class_r <= '0;
      end else begin
        pos_r        <= (pos_r == 7'd127) ? pos_r : pos_r + 7'd1;
        best_score_r <= best_score_nxt;
        best_class_r <= best_class_nxt;
      end
    end
  end

endmodule

[sv/drd_queue.sv]
// Short queue of detection records between front and back ends.
// Depends on drd_pkg for the record type.
module drd_queue #(
  parameter int DEPTH = drd_pkg::Q_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  drd_pkg::det_t              wdata,
  input  logic                       pop,
  output drd_pkg::det_t              rdata,
  output drd_pkg::q_status_t         stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  drd_pkg::det_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign rdata      = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == Full);
  assign stat.empty = (cnt_r == '0);
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/drd_back.sv]
// Back end: scales the box of each queued detection (multiply stage, then
// truncate/saturate into the output register). Depends on drd_pkg.
module drd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  drd_pkg::cfg_t              cfg,
  input  drd_pkg::det_t              q_rdata,
  input  drd_pkg::q_status_t         q_stat,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [drd_pkg::CLS_W-1:0]  out_class_id,
  output logic [drd_pkg::VAL_W-1:0]  out_score,
  output logic signed [12:0]         out_box_left,
  output logic signed [12:0]         out_box_top,
  output logic [11:0]                out_box_width,
  output logic [11:0]                out_box_height
);

  logic                        s1_valid_r;
  logic [drd_pkg::CLS_W-1:0]   s1_class_r;
  logic [drd_pkg::VAL_W-1:0]   s1_score_r;
  logic signed [34:0]          s1_pl_r, s1_pt_r;
  logic [31:0]                 s1_pw_r, s1_ph_r;

  logic signed [17:0]          dx, dy;
  logic signed [34:0]          pl_nxt, pt_nxt;
  logic                        out_valid_r;
  logic                        s2_open;
  logic                        s1_open;

  assign s2_open = !out_valid_r || !out_stall;
  assign s1_open = !s1_valid_r || s2_open;
  assign q_pop   = s1_open && !q_stat.empty;

  assign dx     = $signed({1'b0, q_rdata.cx, 1'b0}) - $signed({2'b00, q_rdata.w});
  assign dy     = $signed({1'b0, q_rdata.cy, 1'b0}) - $signed({2'b00, q_rdata.h});
  assign pl_nxt = dx * $signed({1'b0, cfg.x_scale});
  assign pt_nxt = dy * $signed({1'b0, cfg.y_scale});

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid_r <= !q_stat.empty;
      end
      if (s2_open) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_class_r <= q_rdata.class_id;
      s1_score_r <= q_rdata.score;
      s1_pl_r    <= pl_nxt;
      s1_pt_r    <= pt_nxt;
      s1_pw_r    <= 32'(q_rdata.w) * 32'(cfg.x_scale);
      s1_ph_r    <= 32'(q_rdata.h) * 32'(cfg.y_scale);
    end
    if (s2_open && s1_valid_r) begin
      out_class_id   <= s1_class_r;
      out_score      <= s1_score_r;
      out_box_left   <= drd_pkg::sat_edge(s1_pl_r);
      out_box_top    <= drd_pkg::sat_edge(s1_pt_r);
      out_box_width  <= drd_pkg::sat_extent(s1_pw_r);
      out_box_height <= drd_pkg::sat_extent(s1_ph_r);
    end
  end

endmodule

[sv/detection_row_decoder.sv]
// Detection row decoder top level: configuration registers, front end, queue, back end.
// Depends on drd_pkg, drd_front, drd_queue and drd_back.
//
// Usage:
//   in_*  : one row element per transaction (in_valid/in_stall). Rows are
//           x, y, w, h, [objectness], class scores; in_last_of_row ends a row.
//   out_* : one detection per qualifying row (out_valid/out_stall).
//   cfg_* : register writes (cfg_valid/cfg_ready); cfg_ready is always high.
//           Write only while no row is in flight and the output has drained.
// Throughput: one element per cycle while in_stall is low. The running argmax does one
// compare per element in the front end.
// The queue is written at the edge that accepts a row's last element; the record
// then passes the multiply stage and the output register before out_valid rises.
// The queue holds Q_DEPTH detections; when it is full in_stall is raised.
// Reset clears row state, queue and output valid, and loads register defaults.
// While out_stall is high the output holds; the back end keeps filling its
// multiply stage and the queue, then the front end stalls.
module detection_row_decoder #(
  parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF,
  parameter int Q_DEPTH     = drd_pkg::Q_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [drd_pkg::VAL_W-1:0]       in_element_value,
  input  logic                            in_last_of_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [drd_pkg::CLS_W-1:0]       out_class_id,
  output logic [drd_pkg::VAL_W-1:0]       out_score,
  output logic signed [12:0]              out_box_left,
  output logic signed [12:0]              out_box_top,
  output logic [11:0]                     out_box_width,
  output logic [11:0]                     out_box_height,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  drd_pkg::cfg_t               cfg_r;
  drd_pkg::det_t               q_wdata, q_rdata;
  drd_pkg::q_status_t          q_stat;
  logic                        q_push, q_pop;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout_with_objectness <= 1'b0;
      cfg_r.score_threshold        <= 16'd29491;
      cfg_r.objectness_threshold   <= 16'd16384;
      cfg_r.x_scale                <= 16'd4096;
      cfg_r.y_scale                <= 16'd4096;
      cfg_r.class_mask_low         <= 64'd172;
      cfg_r.class_mask_high        <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drd_pkg::REG_LAYOUT:    cfg_r.layout_with_objectness <= cfg_data[0];
        drd_pkg::REG_SCORE_THR: cfg_r.score_threshold        <= cfg_data[15:0];
        drd_pkg::REG_OBJ_THR:   cfg_r.objectness_threshold   <= cfg_data[15:0];
        drd_pkg::REG_X_SCALE:   cfg_r.x_scale                <= cfg_data[15:0];
        drd_pkg::REG_Y_SCALE:   cfg_r.y_scale                <= cfg_data[15:0];
        drd_pkg::REG_MASK_LOW:  cfg_r.class_mask_low         <= cfg_data;
        drd_pkg::REG_MASK_HIGH: cfg_r.class_mask_high        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  drd_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .in_last_of_row   (in_last_of_row),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  drd_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat),
    .count (q_count)
  );

  drd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_rdata        (q_rdata),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_class_id   (out_class_id),
    .out_score      (out_score),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count <= ($clog2(Q_DEPTH+1))'(Q_DEPTH)))
    else $error("queue count out of range");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> in_stall)
    else $error("input not stalled with full queue");
`endif

endmodule
